@@ rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on an explicit clock and active-low reset.
`define ASSERT_AT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error(msg);

// Same check on the standard clk_i / rst_ni pair.
`define ASSERT_CLK(lbl, prop, msg) \
  `ASSERT_AT(lbl, clk_i, rst_ni, prop, msg)

`endif

@@ rtl/dtar_pkg.sv @@
`timescale 1ns / 1ps

package dtar_pkg;

  // Field widths
  localparam int unsigned DEPTH_W    = 16;
  localparam int unsigned TILE_IDX_W = 10;
  localparam int unsigned ROW_W      = 10;
  localparam int unsigned IMG_W_W    = 11;
  localparam int unsigned IMG_H_W    = 11;
  localparam int unsigned WIN_W      = 4;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Row count limit of the position counter
  localparam int unsigned ROW_LIMIT = 1024;

  // Default sizing
  localparam int unsigned DEF_MAX_WIDTH  = 1024;
  localparam int unsigned DEF_MAX_WINDOW = 8;

  // Register values after reset
  localparam int unsigned RST_IMAGE_WIDTH  = 480;
  localparam int unsigned RST_IMAGE_HEIGHT = 360;
  localparam int unsigned RST_WINDOW       = 4;
  localparam int unsigned RST_FAR_CLIP     = 2500;
  localparam int unsigned RST_RANGE_CAP    = 50;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 3'd0,
    REG_IMAGE_HEIGHT = 3'd1,
    REG_WINDOW_SIZE  = 3'd2,
    REG_FAR_CLIP     = 3'd3,
    REG_RANGE_CAP    = 3'd4
  } cfg_reg_e;

endpackage

@@ rtl/dtar_if.sv @@
`timescale 1ns / 1ps

// Pixel word channel
interface dtar_pix_if;
  logic                         valid;
  logic                         ready;
  logic [dtar_pkg::DEPTH_W-1:0] depth;
  logic                         start_of_frame;

  modport source (output valid, output depth, output start_of_frame, input ready);
  modport sink   (input valid, input depth, input start_of_frame, output ready);
endinterface

// Tile result word channel
interface dtar_tile_if;
  logic                            valid;
  logic                            ready;
  logic [dtar_pkg::DEPTH_W-1:0]    tile_depth;
  logic [dtar_pkg::TILE_IDX_W-1:0] tile_column;
  logic [dtar_pkg::TILE_IDX_W-1:0] tile_row;
  logic                            last_of_frame;

  modport source (output valid, output tile_depth, output tile_column, output tile_row,
                  output last_of_frame, input ready);
  modport sink   (input valid, input tile_depth, input tile_column, input tile_row,
                  input last_of_frame, output ready);
endinterface

@@ rtl/dtar_ram.sv @@
`timescale 1ns / 1ps

// Simple dual-port RAM, one write and one registered read per cycle.
// A read of the entry being written returns the old contents.
module dtar_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/dtar_div.sv @@
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle.
// Quotient and remainder hold after done until the next start.
module dtar_div #(
  parameter int unsigned NW = 22,
  parameter int unsigned DW = 7
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic          busy_o,
  output logic          done_o,
  output logic [NW-1:0] quot_o,
  output logic [DW-1:0] rem_o
);

  localparam int unsigned SW = $clog2(NW + 1);

  logic          busy_q;
  logic          done_q;
  logic [SW-1:0] step_q;
  logic [NW-1:0] quot_q;
  logic [DW-1:0] rem_q;
  logic [DW-1:0] den_q;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          fits;

  // one restoring step
  always_comb begin
    trial = {rem_q, quot_q[NW-1]};
    fits  = trial >= {1'b0, den_q};
    diff  = trial - {1'b0, den_q};
  end

  // step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= SW'(NW);
      end else if (busy_q) begin
        step_q <= step_q - SW'(1);
        if (step_q == SW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // quotient shifts in from the dividend side
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= num_i;
      rem_q  <= '0;
      den_q  <= den_i;
    end else if (busy_q) begin
      quot_q <= {quot_q[NW-2:0], fits};
      rem_q  <= fits ? diff[DW-1:0] : trial[DW-1:0];
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

@@ rtl/depth_tile_average_with_range_reject_top.sv @@
`timescale 1ns / 1ps

// Channel   Port     Dir  Word
// pixel     pix_i    in   depth, start_of_frame
// tile      tile_o   out  tile_depth, tile_column, tile_row, last_of_frame
//
// A pixel that closes no tile does not stall the input; the accumulator entry is read in
// the accept cycle and written back in the next cycle, a forward register covers
// back-to-back pixels of the same tile column.
// A pixel that closes a tile holds the input until its result is in the output register:
// the mean goes through a one-bit-per-cycle serial divider.
// After reset and after every register write the tile position is re-derived
// with serial dividers; the input is held until they are done.
// A finished tile waits in the output register without stalling the input.

`include "assert_macros.svh"

module depth_tile_average_with_range_reject_top #(
  parameter int unsigned MAX_WIDTH  = dtar_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_WINDOW = dtar_pkg::DEF_MAX_WINDOW
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  dtar_pix_if.sink                        pix_i,
  dtar_tile_if.source                     tile_o,
  input  logic                            cfg_we_i,
  input  logic [dtar_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [dtar_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned DW   = dtar_pkg::DEPTH_W;
  localparam int unsigned RW   = dtar_pkg::ROW_W;
  localparam int unsigned CW   = $clog2(MAX_WIDTH);
  localparam int unsigned WW   = $clog2(MAX_WIDTH + 1);
  localparam int unsigned NW   = (WW > dtar_pkg::IMG_W_W) ? WW : dtar_pkg::IMG_W_W;
  localparam int unsigned WSW  = $clog2(MAX_WINDOW + 1);
  localparam int unsigned WSC  = (WSW > dtar_pkg::WIN_W) ? WSW : dtar_pkg::WIN_W;
  localparam int unsigned CNTW = $clog2(MAX_WINDOW * MAX_WINDOW + 1);
  localparam int unsigned SUMW = DW + $clog2(MAX_WINDOW * MAX_WINDOW);
  localparam int unsigned EW   = SUMW + CNTW + 2 * DW;
  localparam int unsigned RST_W =
    (dtar_pkg::RST_IMAGE_WIDTH > MAX_WIDTH) ? MAX_WIDTH : dtar_pkg::RST_IMAGE_WIDTH;
  localparam int unsigned RST_WS =
    (dtar_pkg::RST_WINDOW > MAX_WINDOW) ? MAX_WINDOW : dtar_pkg::RST_WINDOW;

  // true when index ix is the last one of a window
  function automatic logic win_end(input logic [WSW-1:0] ix, input logic [WSW-1:0] ws);
    win_end = ((WSW+1)'(ix) + (WSW+1)'(1)) == (WSW+1)'(ws);
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration registers; width, height and window size are clamped at write
  logic [WW-1:0]   w_q;
  logic [RW:0]     h_q;
  logic [WSW-1:0]  ws_q;
  logic [DW-1:0]   clip_q;
  logic [DW-1:0]   cap_q;
  logic [NW-1:0]   w_raw;
  logic [WW-1:0]   w_clamp;
  logic [RW:0]     h_raw;
  logic [RW:0]     h_clamp;
  logic [WSC-1:0]  ws_raw;
  logic [WSW-1:0]  ws_clamp;

  always_comb begin
    w_raw = NW'(cfg_data_i[dtar_pkg::IMG_W_W-1:0]);
    if (w_raw == '0) begin
      w_clamp = WW'(1);
    end else if (w_raw > NW'(MAX_WIDTH)) begin
      w_clamp = WW'(MAX_WIDTH);
    end else begin
      w_clamp = WW'(w_raw);
    end
    h_raw = (RW+1)'(cfg_data_i[dtar_pkg::IMG_H_W-1:0]);
    if (h_raw == '0) begin
      h_clamp = (RW+1)'(1);
    end else if (h_raw > (RW+1)'(dtar_pkg::ROW_LIMIT)) begin
      h_clamp = (RW+1)'(dtar_pkg::ROW_LIMIT);
    end else begin
      h_clamp = h_raw;
    end
    ws_raw = WSC'(cfg_data_i[dtar_pkg::WIN_W-1:0]);
    if (ws_raw == '0) begin
      ws_clamp = WSW'(1);
    end else if (ws_raw > WSC'(MAX_WINDOW)) begin
      ws_clamp = WSW'(MAX_WINDOW);
    end else begin
      ws_clamp = WSW'(ws_raw);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q    <= WW'(RST_W);
      h_q    <= (RW+1)'(dtar_pkg::RST_IMAGE_HEIGHT);
      ws_q   <= WSW'(RST_WS);
      clip_q <= DW'(dtar_pkg::RST_FAR_CLIP);
      cap_q  <= DW'(dtar_pkg::RST_RANGE_CAP);
    end else if (cfg_we_i) begin
      case (dtar_pkg::cfg_reg_e'(cfg_idx_i))
        dtar_pkg::REG_IMAGE_WIDTH:  w_q    <= w_clamp;
        dtar_pkg::REG_IMAGE_HEIGHT: h_q    <= h_clamp;
        dtar_pkg::REG_WINDOW_SIZE:  ws_q   <= ws_clamp;
        dtar_pkg::REG_FAR_CLIP:     clip_q <= cfg_data_i[DW-1:0];
        dtar_pkg::REG_RANGE_CAP:    cap_q  <= cfg_data_i[DW-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Position re-sync: tile index and offset from the pixel position, tile counts
  logic            sync_pend_q;
  logic            sync_busy;
  logic            sync_done;
  logic            sync_act;
  logic [CW-1:0]   col_q;
  logic [RW-1:0]   row_q;
  logic [NW-1:0]   col_quot;
  logic [WSW-1:0]  col_rem;
  logic [NW-1:0]   row_quot;
  logic [WSW-1:0]  row_rem;
  logic [NW-1:0]   tiles_x;
  logic [NW-1:0]   tiles_y;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_pend_q <= 1'b1;
    end else begin
      sync_pend_q <= cfg_we_i;
    end
  end

  assign sync_act = sync_pend_q | sync_busy | sync_done;

  dtar_div #(.NW(NW), .DW(WSW)) u_div_col (
    .clk_i, .rst_ni, .start_i(sync_pend_q), .num_i(NW'(col_q)), .den_i(ws_q),
    .busy_o(sync_busy), .done_o(sync_done), .quot_o(col_quot), .rem_o(col_rem)
  );

  dtar_div #(.NW(NW), .DW(WSW)) u_div_row (
    .clk_i, .rst_ni, .start_i(sync_pend_q), .num_i(NW'(row_q)), .den_i(ws_q),
    .busy_o(), .done_o(), .quot_o(row_quot), .rem_o(row_rem)
  );

  dtar_div #(.NW(NW), .DW(WSW)) u_div_w (
    .clk_i, .rst_ni, .start_i(sync_pend_q), .num_i(NW'(w_q)), .den_i(ws_q),
    .busy_o(), .done_o(), .quot_o(tiles_x), .rem_o()
  );

  dtar_div #(.NW(NW), .DW(WSW)) u_div_h (
    .clk_i, .rst_ni, .start_i(sync_pend_q), .num_i(NW'(h_q)), .den_i(ws_q),
    .busy_o(), .done_o(), .quot_o(tiles_y), .rem_o()
  );

  // ---------------------------------------------------------------------------
  // Stage 0: position of the arriving pixel, accumulator read
  logic            acc;
  logic            mean_busy;
  logic            mean_done;
  logic            res_pend_q;
  logic            s1_v_q;
  logic            s1_emit_q;
  logic [WSW-1:0]  cx_q, ry_q;
  logic [CW-1:0]   tc_q;
  logic [RW-1:0]   tr_q;
  logic [CW-1:0]   c0, tc0;
  logic [WSW-1:0]  cx0, ry0, ry1;
  logic [RW-1:0]   r0, tr0;
  logic [RW:0]     r1, tr1;
  logic [CW-1:0]   p_col, p_tc;
  logic [WSW-1:0]  p_cx, p_ry;
  logic [RW-1:0]   p_row, p_tr;
  logic            p_valid, p_first, p_emit, p_last;

  assign pix_i.ready = !sync_act && !mean_busy && !mean_done && !res_pend_q &&
                       !(s1_v_q && s1_emit_q);
  assign acc = pix_i.valid && pix_i.ready;

  always_comb begin
    c0  = col_q;
    cx0 = cx_q;
    tc0 = tc_q;
    r0  = row_q;
    ry0 = ry_q;
    tr0 = tr_q;
    if (pix_i.start_of_frame) begin
      c0  = '0;
      cx0 = '0;
      tc0 = '0;
      r0  = '0;
      ry0 = '0;
      tr0 = '0;
    end
    // column left past a smaller width: move to the next row
    p_col = c0;
    p_cx  = cx0;
    p_tc  = tc0;
    r1    = (RW+1)'(r0);
    ry1   = ry0;
    tr1   = (RW+1)'(tr0);
    if (NW'(c0) >= NW'(w_q)) begin
      p_col = '0;
      p_cx  = '0;
      p_tc  = '0;
      r1    = r1 + (RW+1)'(1);
      if (win_end(ry0, ws_q)) begin
        ry1 = '0;
        tr1 = tr1 + (RW+1)'(1);
      end else begin
        ry1 = ry0 + WSW'(1);
      end
    end
    if (r1 >= h_q) begin
      p_row = '0;
      p_ry  = '0;
      p_tr  = '0;
    end else begin
      p_row = r1[RW-1:0];
      p_ry  = ry1;
      p_tr  = tr1[RW-1:0];
    end
    p_valid = (pix_i.depth != '0) && (pix_i.depth < clip_q);
    p_first = (p_cx == '0) && (p_ry == '0);
    p_emit  = win_end(p_cx, ws_q) && win_end(p_ry, ws_q);
    p_last  = ((NW'(p_tc) + NW'(1)) == tiles_x) && ((NW'(p_tr) + NW'(1)) == tiles_y);
  end

  // position after this pixel
  logic [CW:0]     ncol;
  logic [RW:0]     r2, tr2;
  logic [WSW-1:0]  ry2;
  logic [CW-1:0]   col_d, tc_d;
  logic [WSW-1:0]  cx_d, ry_d;
  logic [RW-1:0]   row_d, tr_d;

  always_comb begin
    ncol  = (CW+1)'(p_col) + (CW+1)'(1);
    col_d = ncol[CW-1:0];
    cx_d  = p_cx;
    tc_d  = p_tc;
    r2    = (RW+1)'(p_row);
    ry2   = p_ry;
    tr2   = (RW+1)'(p_tr);
    if (NW'(ncol) >= NW'(w_q)) begin
      col_d = '0;
      cx_d  = '0;
      tc_d  = '0;
      r2    = r2 + (RW+1)'(1);
      if (win_end(p_ry, ws_q)) begin
        ry2 = '0;
        tr2 = tr2 + (RW+1)'(1);
      end else begin
        ry2 = p_ry + WSW'(1);
      end
    end else if (win_end(p_cx, ws_q)) begin
      cx_d = '0;
      tc_d = p_tc + CW'(1);
    end else begin
      cx_d = p_cx + WSW'(1);
    end
    if (r2 >= h_q) begin
      row_d = '0;
      ry_d  = '0;
      tr_d  = '0;
    end else begin
      row_d = r2[RW-1:0];
      ry_d  = ry2;
      tr_d  = tr2[RW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      cx_q  <= '0;
      tc_q  <= '0;
      ry_q  <= '0;
      tr_q  <= '0;
    end else if (acc) begin
      col_q <= col_d;
      row_q <= row_d;
      cx_q  <= cx_d;
      tc_q  <= tc_d;
      ry_q  <= ry_d;
      tr_q  <= tr_d;
    end else if (sync_done) begin
      tc_q <= CW'(col_quot);
      cx_q <= col_rem;
      tr_q <= RW'(row_quot);
      ry_q <= row_rem;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: modify the accumulator entry and write it back
  logic [CW-1:0]   s1_tc_q;
  logic [RW-1:0]   s1_tr_q;
  logic [DW-1:0]   s1_d_q;
  logic            s1_valid_q, s1_first_q, s1_last_q;
  logic [EW-1:0]   rdata;
  logic [EW-1:0]   ent;
  logic [EW-1:0]   wdata;
  logic            we;
  logic            fw_v_q;
  logic [CW-1:0]   fw_addr_q;
  logic [EW-1:0]   fw_data_q;
  logic [SUMW-1:0] e_sum, n_sum;
  logic [CNTW-1:0] e_cnt, n_cnt;
  logic [DW-1:0]   e_min, e_max, n_min, n_max;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else begin
      s1_v_q <= acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_tc_q    <= p_tc;
      s1_tr_q    <= p_tr;
      s1_d_q     <= pix_i.depth;
      s1_valid_q <= p_valid;
      s1_first_q <= p_first;
      s1_emit_q  <= p_emit;
      s1_last_q  <= p_last;
    end
  end

  dtar_ram #(.WIDTH(EW), .DEPTH(MAX_WIDTH)) u_acc_ram (
    .clk_i,
    .we_i    (we),
    .waddr_i (s1_tc_q),
    .wdata_i (wdata),
    .raddr_i (p_tc),
    .rdata_o (rdata)
  );

  always_comb begin
    // the previous write has not reached the read data yet
    ent = (fw_v_q && (fw_addr_q == s1_tc_q)) ? fw_data_q : rdata;
    {e_sum, e_cnt, e_min, e_max} = ent;
    n_sum = e_sum;
    n_cnt = e_cnt;
    n_min = e_min;
    n_max = e_max;
    if (s1_first_q) begin
      n_sum = s1_valid_q ? SUMW'(s1_d_q) : '0;
      n_cnt = s1_valid_q ? CNTW'(1) : '0;
      n_min = s1_valid_q ? s1_d_q : '0;
      n_max = s1_valid_q ? s1_d_q : '0;
    end else if (s1_valid_q) begin
      if ((e_cnt == '0) || (s1_d_q < e_min)) begin
        n_min = s1_d_q;
      end
      if ((e_cnt == '0) || (s1_d_q > e_max)) begin
        n_max = s1_d_q;
      end
      n_sum = e_sum + SUMW'(s1_d_q);
      n_cnt = e_cnt + CNTW'(1);
    end
    wdata = {n_sum, n_cnt, n_min, n_max};
    we    = s1_v_q && (s1_first_q || s1_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_v_q <= 1'b0;
    end else if (we) begin
      fw_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      fw_addr_q <= s1_tc_q;
      fw_data_q <= wdata;
    end
  end

  // ---------------------------------------------------------------------------
  // Mean of a closed tile
  logic            mean_start;
  logic [SUMW-1:0] mean_quot;
  logic [DW-1:0]   em_min_q, em_max_q;
  logic            em_zero_q;
  logic [CW-1:0]   em_tc_q;
  logic [RW-1:0]   em_tr_q;
  logic            em_last_q;

  assign mean_start = s1_v_q && s1_emit_q;

  dtar_div #(.NW(SUMW), .DW(CNTW)) u_div_mean (
    .clk_i, .rst_ni, .start_i(mean_start), .num_i(n_sum), .den_i(n_cnt),
    .busy_o(mean_busy), .done_o(mean_done), .quot_o(mean_quot), .rem_o()
  );

  always_ff @(posedge clk_i) begin
    if (mean_start) begin
      em_min_q  <= n_min;
      em_max_q  <= n_max;
      em_zero_q <= (n_cnt == '0);
      em_tc_q   <= s1_tc_q;
      em_tr_q   <= s1_tr_q;
      em_last_q <= s1_last_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  logic          out_v_q;
  logic          out_load;
  logic          reject;
  logic [DW-1:0] out_depth_q;
  logic [dtar_pkg::TILE_IDX_W-1:0] out_col_q, out_row_q;
  logic          out_last_q;

  assign out_load = res_pend_q && (!out_v_q || tile_o.ready);
  assign reject   = em_zero_q ||
                    ((em_max_q >= em_min_q) && ((em_max_q - em_min_q) > cap_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_pend_q <= 1'b0;
      out_v_q    <= 1'b0;
    end else begin
      if (mean_done) begin
        res_pend_q <= 1'b1;
      end else if (out_load) begin
        res_pend_q <= 1'b0;
      end
      if (out_load) begin
        out_v_q <= 1'b1;
      end else if (tile_o.ready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_depth_q <= reject ? '0 : DW'(mean_quot);
      out_col_q   <= dtar_pkg::TILE_IDX_W'(em_tc_q);
      out_row_q   <= dtar_pkg::TILE_IDX_W'(em_tr_q);
      out_last_q  <= em_last_q;
    end
  end

  assign tile_o.valid         = out_v_q;
  assign tile_o.tile_depth    = out_depth_q;
  assign tile_o.tile_column   = out_col_q;
  assign tile_o.tile_row      = out_row_q;
  assign tile_o.last_of_frame = out_last_q;

  // ---------------------------------------------------------------------------
  // Checks
  `ASSERT_CLK(a_mean_free, mean_start |-> (!mean_busy && !res_pend_q), "mean divider in use")
  `ASSERT_CLK(a_result_held, mean_done |-> !res_pend_q, "tile result overwritten")
  `ASSERT_CLK(a_result_moves, (res_pend_q && !out_v_q) |=> (out_v_q && !res_pend_q),
              "tile result not moved to output")

endmodule
